### src/raster_line_counter_irq_unit_assert.svh
// Assertion macros for the raster line counter blocks.
`ifndef RASTER_LINE_COUNTER_IRQ_UNIT_ASSERT_SVH
`define RASTER_LINE_COUNTER_IRQ_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Clocked check, masked while reset is high.
`define RLC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("raster line counter check failed");

// Clocked check that also holds through reset.
`define RLC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("raster line counter check failed");

`else

`define RLC_ASSERT(lbl, clk, rst, prop)
`define RLC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### src/rlc_pkg.sv
// Shared types and constants of the raster line counter.
package rlc_pkg;

   localparam int CplWidth = 8;
   localparam int LpfWidth = 10;
   localparam int RowWidth = 9;
   localparam int AccWidth = 9;
   localparam int CycWidth = 7;
   localparam int CsrDataWidth = 10;

   localparam logic [CplWidth-1:0] CPL_RESET = 8'd63;
   localparam logic [LpfWidth-1:0] LPF_RESET = 10'd312;

   // Operation codes
   localparam logic [1:0] OP_ADVANCE = 2'd0;
   localparam logic [1:0] OP_ACK     = 2'd1;
   localparam logic [1:0] OP_WRITE   = 2'd2;

   // Register indexes
   localparam logic CSR_CYCLES_PER_LINE = 1'b0;
   localparam logic CSR_LINES_PER_FRAME = 1'b1;

   typedef struct packed {
      logic [1:0]          operation;
      logic [CycWidth-1:0] elapsed_cycles;
      logic [RowWidth-1:0] compare_value;
      logic                compare_on;
   } req_type;

   typedef struct packed {
      logic [RowWidth-1:0] current_row;
      logic                irq_pending;
   } rsp_type;

   typedef struct packed {
      logic [CplWidth-1:0] cycles_per_line;
      logic [LpfWidth-1:0] lines_per_frame;
   } cfg_type;

endpackage

### src/rlc_csr.sv
// Configuration registers: cycles per line and lines per frame.
module rlc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [rlc_pkg::CsrDataWidth-1:0]  csr_wdata,
   output rlc_pkg::cfg_type                  cfg
);
   import rlc_pkg::*;

   logic [CplWidth-1:0] cpl_ff;
   logic [LpfWidth-1:0] lpf_ff;

   // Load the addressed register on a write transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         cpl_ff <= CPL_RESET;
         lpf_ff <= LPF_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CYCLES_PER_LINE: cpl_ff <= csr_wdata[CplWidth-1:0];
            CSR_LINES_PER_FRAME: lpf_ff <= csr_wdata[LpfWidth-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.cycles_per_line = cpl_ff;
   assign cfg.lines_per_frame = lpf_ff;

endmodule

### src/rlc_engine.sv
// Raster state and the single-pass update for one item.
`include "raster_line_counter_irq_unit_assert.svh"

module rlc_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  rlc_pkg::req_type req,
   input  rlc_pkg::cfg_type cfg,
   output rlc_pkg::rsp_type rsp
);
   import rlc_pkg::*;

   logic [AccWidth-1:0] acc_ff, acc_in;
   logic [RowWidth-1:0] row_ff, row_in;
   logic                pend_ff, pend_in;
   logic [RowWidth-1:0] match_row_ff, match_row_in;
   logic                match_en_ff, match_en_in;

   logic [AccWidth:0]   sum;
   logic [AccWidth:0]   diff;
   logic                reach;
   logic [RowWidth-1:0] row_inc;
   logic [RowWidth-1:0] row_step;

   // Accumulate cycles and find the line crossing
   assign sum     = {1'b0, acc_ff} + {{(AccWidth+1-CycWidth){1'b0}}, req.elapsed_cycles};
   assign reach   = sum >= {{(AccWidth+1-CplWidth){1'b0}}, cfg.cycles_per_line};
   assign diff    = sum - {{(AccWidth+1-CplWidth){1'b0}}, cfg.cycles_per_line};
   assign row_inc = row_ff + 1'b1;
   assign row_step = ({1'b0, row_inc} >= cfg.lines_per_frame) ? '0 : row_inc;

   // Next state for the item being processed
   always_comb begin
      acc_in       = acc_ff;
      row_in       = row_ff;
      pend_in      = pend_ff;
      match_row_in = match_row_ff;
      match_en_in  = match_en_ff;
      unique case (req.operation)
         OP_ADVANCE: begin
            if (reach) begin
               row_in = row_step;
               if (match_en_ff && (row_step == match_row_ff)) begin
                  pend_in = 1'b1;
               end
               acc_in = diff[AccWidth] ? '1 : diff[AccWidth-1:0];
            end else begin
               acc_in = sum[AccWidth] ? '1 : sum[AccWidth-1:0];
            end
         end
         OP_ACK: begin
            pend_in = 1'b0;
         end
         OP_WRITE: begin
            match_row_in = req.compare_value;
            match_en_in  = req.compare_on;
         end
         default: ;
      endcase
   end

   // Commit state when an item is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         row_ff       <= '0;
         pend_ff      <= 1'b0;
         match_row_ff <= '0;
         match_en_ff  <= 1'b0;
      end else if (fire) begin
         acc_ff       <= acc_in;
         row_ff       <= row_in;
         pend_ff      <= pend_in;
         match_row_ff <= match_row_in;
         match_en_ff  <= match_en_in;
      end
   end

   // Result reflects the state after this item
   assign rsp.current_row = row_in;
   assign rsp.irq_pending = pend_in;

   `RLC_ASSERT(a_ack_clears, clock, reset, fire && (req.operation == OP_ACK) |=> !pend_ff)
   `RLC_ASSERT(a_row_only_on_advance, clock, reset,
      fire && (req.operation != OP_ADVANCE) |=> $stable(row_ff))
   `RLC_ASSERT(a_write_loads_match, clock, reset,
      fire && (req.operation == OP_WRITE) |=> match_row_ff == $past(req.compare_value))

endmodule

### src/raster_line_counter_irq_unit.sv
// A request is taken into the input register and processed when the result register
// can load; its result is then held there until transfer. Throughput: one item per
// cycle unless the result side stalls; the state update is one add, compare, subtract.
// Input and result registers are split, so one request is taken while a result waits.
// Reset (synchronous, active high) clears row, accumulator, flag and compare settings,
// and loads the cycles-per-line register with 63 and the lines-per-frame register with 312.
module raster_line_counter_irq_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  rlc_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rlc_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [rlc_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import rlc_pkg::*;

   req_type req_ff;
   logic    req_vld_ff;
   rsp_type rsp_ff;
   logic    rsp_vld_ff;
   rsp_type rsp_in;
   cfg_type cfg;
   logic    rsp_free;
   logic    fire;
   logic    req_take;

   // Handshake: process when a request is held and the result slot can load
   assign rsp_free  = !rsp_vld_ff || !rsp_stall;
   assign fire      = req_vld_ff && rsp_free;
   assign req_stall = req_vld_ff && !rsp_free;
   assign req_take  = req_valid && !req_stall;

   rlc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rlc_engine u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req_ff),
      .cfg   (cfg),
      .rsp   (rsp_in)
   );

   // Input register: hold the request until processed
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (!req_vld_ff || fire) begin
         req_vld_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_payload;
      end
   end

   // Result register: load on processing, drop on result transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_vld_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

endmodule

### tb/tb.sv
// Self-checking testbench for the raster line counter with compare interrupt.
`timescale 1ns / 100ps

module tb;
   import rlc_pkg::*;

   // Operation code that the block must ignore
   localparam logic [1:0] OpUnused = 2'd3;
   localparam logic [AccWidth-1:0] AccSaturate = 9'h1FF;
   localparam int CycleLimit = 400000;
   localparam int HoldCycles = 80;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } vector_entry_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   req_type                 req_payload;
   logic                    rsp_valid;
   logic                    rsp_stall;
   rsp_type                 rsp_payload;
   logic                    csr_we;
   logic                    csr_index;
   logic [CsrDataWidth-1:0] csr_wdata;

   // Shadow of the raster state and its line/frame setup
   logic [CplWidth-1:0] cpl_q;
   logic [LpfWidth-1:0] lpf_q;
   logic [AccWidth-1:0] acc_q;
   logic [RowWidth-1:0] row_q;
   logic                flag_q;
   logic [RowWidth-1:0] match_row_q;
   logic                match_en_q;

   rsp_type          row_irq_due[$];
   vector_entry_type directed_vectors[18];
   int               mismatch_count;
   int               cycle_count;
   int               send_idle_pct;
   int               take_idle_pct;
   int               hold_requests;
   int               hold_served;
   int               hold_left;

   raster_line_counter_irq_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Advance the shadow state by one item and return the row and flag it leaves
   function automatic rsp_type step_raster(req_type item);
      logic [AccWidth:0]   sum;
      logic [RowWidth-1:0] next_row;
      rsp_type             res;
      case (item.operation)
         OP_ADVANCE: begin
            sum = {1'b0, acc_q} + item.elapsed_cycles;
            if (sum >= cpl_q) begin
               sum = sum - cpl_q;
               next_row = row_q + 1'b1;
               if (next_row >= lpf_q) next_row = '0;
               row_q = next_row;
               if (match_en_q && next_row == match_row_q) flag_q = 1'b1;
            end
            // Clamp the backlog left after a shortened line
            acc_q = (sum > AccSaturate) ? AccSaturate : sum[AccWidth-1:0];
         end
         OP_ACK: flag_q = 1'b0;
         OP_WRITE: begin
            match_row_q = item.compare_value;
            match_en_q = item.compare_on;
         end
         default: ;
      endcase
      res.current_row = row_q;
      res.irq_pending = flag_q;
      return res;
   endfunction

   // Build a random item; compare rows are often placed just ahead of the row
   function automatic req_type random_item(int adv_pct);
      req_type item;
      int      pick;
      item.elapsed_cycles = CycWidth'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 127)
                                                                 : $urandom_range(0, 3));
      item.compare_value = RowWidth'($urandom_range(0, 1) ? row_q + $urandom_range(0, 3)
                                                          : $urandom_range(0, 511));
      item.compare_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 99) < adv_pct) item.operation = OP_ADVANCE;
      else if (pick < 4) item.operation = OP_WRITE;
      else if (pick < 8) item.operation = OP_ACK;
      else item.operation = OpUnused;
      return item;
   endfunction

   // Offer one item, hold it until the transfer, then record what it must return
   task automatic send_item(req_type item, bit typed, rsp_type want);
      rsp_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      predicted = step_raster(item);
      row_irq_due.push_back(typed ? want : predicted);
   endtask

   task automatic drain();
      while (row_irq_due.size() != 0) @(posedge clock);
   endtask

   // Quiesce, load both line/frame registers, then run a batch of random items
   task automatic run_phase(logic [CplWidth-1:0] cpl, logic [LpfWidth-1:0] lpf, int count,
                            int adv_pct, int send_pct, int take_pct, bit long_hold);
      rsp_type none;
      req_type item;
      int      sent;
      none = '0;
      sent = 0;
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_CYCLES_PER_LINE;
      csr_wdata <= {2'($urandom_range(0, 3)), cpl};
      @(posedge clock);
      cpl_q = cpl;
      csr_index <= CSR_LINES_PER_FRAME;
      csr_wdata <= lpf;
      @(posedge clock);
      lpf_q = lpf;
      csr_we <= 1'b0;
      send_idle_pct = send_pct;
      take_idle_pct = take_pct;
      if (long_hold) hold_requests++;
      while (sent < count) begin
         item = random_item(adv_pct);
         send_item(item, 1'b0, none);
         if (item.operation != OpUnused) sent++;
      end
      req_valid <= 1'b0;
   endtask

   // Result side: random stall, plus a long hold-off when one is requested
   initial begin
      rsp_stall = 1'b0;
      hold_served = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < take_idle_pct);
         end
      end
   end

   // Compare each result transfer with the oldest outstanding expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (row_irq_due.size() == 0) begin
            $display("%0t: result with nothing outstanding, row %0d irq %0d", $time,
                     rsp_payload.current_row, rsp_payload.irq_pending);
            mismatch_count++;
         end else begin
            want = row_irq_due.pop_front();
            if (rsp_payload.current_row !== want.current_row) begin
               $display("%0t: current_row expected %0d, got %0d", $time,
                        want.current_row, rsp_payload.current_row);
               mismatch_count++;
            end
            if (rsp_payload.irq_pending !== want.irq_pending) begin
               $display("%0t: irq_pending expected %0d, got %0d", $time,
                        want.irq_pending, rsp_payload.irq_pending);
               mismatch_count++;
            end
         end
      end
   end

   // Abort a hung run
   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("raster_line_counter_irq_unit: mismatch");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_index = CSR_CYCLES_PER_LINE;
      csr_wdata = '0;
      mismatch_count = 0;
      hold_requests = 0;
      send_idle_pct = 24;
      take_idle_pct = 72;
      cpl_q = CPL_RESET;
      lpf_q = LPF_RESET;
      acc_q = '0;
      row_q = '0;
      flag_q = 1'b0;
      match_row_q = '0;
      match_en_q = 1'b0;

      // Directed rows at the reset setup: line length 63, frame length 312
      directed_vectors = '{
         '{'{OP_ACK,     7'd0,   9'd0,   1'b0}, 1'b1, '{9'd0, 1'b0}},
         '{'{OpUnused,   7'd127, 9'd511, 1'b1}, 1'b1, '{9'd0, 1'b0}},
         '{'{OP_WRITE,   7'd127, 9'd1,   1'b1}, 1'b1, '{9'd0, 1'b0}},
         '{'{OP_ADVANCE, 7'd62,  9'd0,   1'b0}, 1'b1, '{9'd0, 1'b0}},
         '{'{OP_ADVANCE, 7'd1,   9'd0,   1'b0}, 1'b1, '{9'd1, 1'b1}},
         '{'{OP_ADVANCE, 7'd0,   9'd511, 1'b1}, 1'b1, '{9'd1, 1'b1}},
         '{'{OP_ACK,     7'd127, 9'd511, 1'b1}, 1'b1, '{9'd1, 1'b0}},
         '{'{OP_ACK,     7'd0,   9'd0,   1'b0}, 1'b1, '{9'd1, 1'b0}},
         '{'{OP_WRITE,   7'd0,   9'd511, 1'b1}, 1'b1, '{9'd1, 1'b0}},
         '{'{OP_ADVANCE, 7'd127, 9'd0,   1'b0}, 1'b0, '{9'd0, 1'b0}},
         '{'{OP_ADVANCE, 7'd127, 9'd0,   1'b0}, 1'b0, '{9'd0, 1'b0}},
         '{'{OP_WRITE,   7'd0,   9'd5,   1'b1}, 1'b0, '{9'd0, 1'b0}},
         '{'{OP_ADVANCE, 7'd127, 9'd0,   1'b0}, 1'b0, '{9'd0, 1'b0}},
         '{'{OP_ADVANCE, 7'd127, 9'd0,   1'b0}, 1'b0, '{9'd0, 1'b0}},
         '{'{OP_ADVANCE, 7'd127, 9'd0,   1'b0}, 1'b0, '{9'd0, 1'b0}},
         '{'{OP_WRITE,   7'd0,   9'd0,   1'b0}, 1'b0, '{9'd0, 1'b0}},
         '{'{OP_ADVANCE, 7'd127, 9'd0,   1'b0}, 1'b0, '{9'd0, 1'b0}},
         '{'{OP_ACK,     7'd0,   9'd0,   1'b0}, 1'b0, '{9'd0, 1'b0}}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_vectors[i])
         send_item(directed_vectors[i].item, directed_vectors[i].typed,
                   directed_vectors[i].want);
      req_valid <= 1'b0;

      // Sender mostly offering, receiver mostly stalling
      run_phase(8'd0,   10'd1023, 600, 90, 24, 72, 1'b0);
      run_phase(8'd1,   10'd0,    120, 60, 24, 72, 1'b0);
      run_phase(8'd255, 10'd1,    120, 60, 24, 72, 1'b0);
      // Sender mostly idle, receiver mostly taking
      run_phase(8'd255, 10'd512,  120, 60, 72, 24, 1'b0);
      run_phase(8'd5,   10'd20,   200, 60, 72, 24, 1'b0);
      run_phase(CPL_RESET, LPF_RESET, 200, 60, 72, 24, 1'b0);
      // No idling; the first batch opens with a long result hold-off
      run_phase(8'($urandom_range(0, 255)), 10'($urandom_range(1, 40)), 200, 60, 0, 0, 1'b1);
      run_phase(8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)), 120, 60, 0, 0, 1'b0);
      run_phase(8'($urandom_range(0, 63)), 10'($urandom_range(1, 40)), 120, 70, 0, 0, 1'b0);

      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("raster_line_counter_irq_unit: match");
      else
         $display("raster_line_counter_irq_unit: mismatch");
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/rlc_pkg.sv
src/rlc_csr.sv
src/rlc_engine.sv
src/raster_line_counter_irq_unit.sv
tb/tb.sv
